[hw/rtl/lmie_pkg.sv]
// ----------------------------------------------------------------------------
// lmie_pkg
// shared types and constants of the llr mutual information estimator
// ----------------------------------------------------------------------------
package lmie_pkg;

    localparam int METRIC_W = 16;
    localparam int REF_W    = 4;
    localparam int RUN_W    = 20;
    localparam int DEV_W    = 20;
    localparam int SUM_W    = 48;
    localparam int CNT_W    = 24;
    localparam int BITS_W   = 3;
    localparam int OUT_W    = 16;

    // 1/ln2 in q30
    localparam int LOG2E_W = 31;
    localparam logic [LOG2E_W-1:0] LOG2E_Q30 = 31'd1549082005;

    // sum * 1/ln2 split into two 24-bit halves
    localparam int HALF_W = SUM_W / 2;
    localparam int PROD_W = HALF_W + LOG2E_W;
    localparam int PRODX_W = SUM_W + LOG2E_W;

    // dividend is (sum * 1/ln2) * 16
    localparam int DVD_W     = PRODX_W + 4;
    localparam int DIV_STEPS = DVD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // quotient at or above 2^20 * (1/ln2 in q30) means the ratio is out of range
    localparam logic [DVD_W-1:0] SAT_LIMIT = DVD_W'(LOG2E_Q30) << 20;
    localparam int T_SRC_W = 51;
    localparam int T_W     = T_SRC_W + 1 - 30;
    localparam logic [T_SRC_W:0] ROUND_Q30 = (T_SRC_W + 1)'(1) << 29;

    localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7FFF;

    // round(256 * ln(1 + exp(-k/8)))
    localparam logic [7:0] CORR_BASE [64] = '{
        8'd177, 8'd162, 8'd147, 8'd134, 8'd121, 8'd110, 8'd99, 8'd89,
        8'd80,  8'd72,  8'd64,  8'd58,  8'd52,  8'd46,  8'd41, 8'd37,
        8'd32,  8'd29,  8'd26,  8'd23,  8'd20,  8'd18,  8'd16, 8'd14,
        8'd12,  8'd11,  8'd10,  8'd9,   8'd8,   8'd7,   8'd6,  8'd5,
        8'd5,   8'd4,   8'd4,   8'd3,   8'd3,   8'd2,   8'd2,  8'd2,
        8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,  8'd1,
        8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,  8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,  8'd0
    };

    typedef struct packed {
        logic mul_lo;
        logic mul_hi;
        logic dvd_load;
        logic div_step;
        logic out_load;
    } t_est_cmd;

    typedef struct packed {
        logic out_free;
    } t_est_sts;

endpackage

[hw/rtl/lmie_if.sv]
// ----------------------------------------------------------------------------
// lmie_if
// valid/ready stream channels for metrics in and estimates out
// ----------------------------------------------------------------------------
interface lmie_in_if;
    logic                     valid;
    logic                     ready;
    logic signed [15:0]       metric;
    logic [3:0]               ref_bits;
    logic                     frame_end;

    modport source (output valid, output metric, output ref_bits, output frame_end,
                    input ready);
    modport sink   (input valid, input metric, input ref_bits, input frame_end,
                    output ready);
endinterface

interface lmie_out_if;
    logic                     valid;
    logic                     ready;
    logic signed [15:0]       mi_estimate;
    logic                     incomplete;

    modport source (output valid, output mi_estimate, output incomplete,
                    input ready);
    modport sink   (input valid, input mi_estimate, input incomplete,
                    output ready);
endinterface

[hw/rtl/lmie_accum.sv]
// ----------------------------------------------------------------------------
// lmie_accum
// per-metric max* tracking and per-symbol deviation accumulation
// ----------------------------------------------------------------------------
module lmie_accum #(
    parameter int MAX_SYMBOL_BITS        = 4,
    parameter int CORRECTION_TABLE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic signed [lmie_pkg::METRIC_W-1:0] i_metric,
    input  logic [lmie_pkg::REF_W-1:0]          i_ref_bits,
    input  logic [lmie_pkg::BITS_W-1:0]         i_eff_bits,
    input  logic [lmie_pkg::CNT_W-1:0]          i_min_len,
    output logic [lmie_pkg::SUM_W-1:0]          o_sum,
    output logic [lmie_pkg::CNT_W-1:0]          o_count
);

    localparam int PW  = MAX_SYMBOL_BITS;
    localparam int IW  = (CORRECTION_TABLE_DEPTH > 1) ? $clog2(CORRECTION_TABLE_DEPTH) : 1;
    localparam int DW  = $clog2(CORRECTION_TABLE_DEPTH + 1);
    localparam int PRW = 11 + DW;

    logic [PW-1:0]                           r_pos;
    logic [PW-1:0]                           r_ref_idx;
    logic signed [lmie_pkg::RUN_W-1:0]       r_run;
    logic signed [lmie_pkg::METRIC_W-1:0]    r_ref_metric;
    logic                                    r_s2_vld;
    logic [lmie_pkg::DEV_W-1:0]              r_s2_dev;
    logic [lmie_pkg::SUM_W-1:0]              r_sum;
    logic [lmie_pkg::CNT_W-1:0]              r_count;

    logic [7:0]                              w_tab [CORRECTION_TABLE_DEPTH];
    logic [PW:0]                             w_one_sh;
    logic [PW-1:0]                           w_last;
    logic [PW-1:0]                           w_idx_in;
    logic                                    w_first;
    logic signed [lmie_pkg::RUN_W-1:0]       w_m20;
    logic signed [lmie_pkg::RUN_W:0]         w_diff;
    logic [lmie_pkg::RUN_W:0]                w_ad;
    logic                                    w_in_range;
    logic [PRW-1:0]                          w_prod;
    logic [IW-1:0]                           w_tidx;
    logic [7:0]                              w_corr;
    logic signed [lmie_pkg::RUN_W-1:0]       w_max;
    logic signed [lmie_pkg::RUN_W-1:0]       w_new_run;
    logic [PW-1:0]                           w_new_ref_idx;
    logic signed [lmie_pkg::METRIC_W-1:0]    w_new_ref_m;
    logic                                    w_end;
    logic signed [lmie_pkg::RUN_W:0]         w_dev_raw;
    logic [lmie_pkg::DEV_W-1:0]              w_dev;

    // correction table resampled from the 64-entry base
    for (genvar g = 0; g < CORRECTION_TABLE_DEPTH; g++) begin : g_tab
        localparam int K = (g * 64) / CORRECTION_TABLE_DEPTH;
        assign w_tab[g] = lmie_pkg::CORR_BASE[K];
    end

    assign w_one_sh = (PW + 1)'(1) << i_eff_bits;
    assign w_last   = PW'(w_one_sh - 1'b1);
    assign w_idx_in = PW'(i_ref_bits) & w_last;
    assign w_first  = (r_pos == '0);

    assign w_m20  = $signed({{(lmie_pkg::RUN_W - lmie_pkg::METRIC_W){i_metric[15]}}, i_metric});
    assign w_diff = $signed({r_run[lmie_pkg::RUN_W-1], r_run}) -
                    $signed({w_m20[lmie_pkg::RUN_W-1], w_m20});
    assign w_ad   = w_diff[lmie_pkg::RUN_W] ? (lmie_pkg::RUN_W + 1)'(-w_diff) : w_diff;

    // table covers |a-b| below 8.0 in q8.8
    assign w_in_range = (w_ad[lmie_pkg::RUN_W:11] == '0);
    assign w_prod     = PRW'(w_ad[10:0]) * PRW'(CORRECTION_TABLE_DEPTH);
    assign w_tidx     = w_prod[11 +: IW];
    assign w_corr     = w_in_range ? w_tab[w_tidx] : 8'd0;

    assign w_max     = (r_run > w_m20) ? r_run : w_m20;
    assign w_new_run = w_first ? w_m20
                               : w_max + $signed({{(lmie_pkg::RUN_W - 8){1'b0}}, w_corr});

    assign w_new_ref_idx = w_first ? w_idx_in : r_ref_idx;
    assign w_new_ref_m   = (r_pos == w_new_ref_idx) ? i_metric : r_ref_metric;
    assign w_end         = (r_pos >= w_last);

    assign w_dev_raw = $signed({w_new_run[lmie_pkg::RUN_W-1], w_new_run}) -
                       $signed({{(lmie_pkg::RUN_W + 1 - lmie_pkg::METRIC_W){w_new_ref_m[15]}},
                                w_new_ref_m});
    assign w_dev     = w_dev_raw[lmie_pkg::RUN_W] ? '0 : w_dev_raw[lmie_pkg::DEV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_ref_idx    <= '0;
            r_run        <= '0;
            r_ref_metric <= '0;
            r_s2_vld     <= 1'b0;
            r_sum        <= '0;
            r_count      <= '0;
        end else begin
            r_s2_vld <= 1'b0;
            if (i_accept) begin
                r_run        <= w_new_run;
                r_ref_idx    <= w_new_ref_idx;
                r_ref_metric <= w_new_ref_m;
                if (w_end) begin
                    r_pos    <= '0;
                    r_s2_vld <= 1'b1;
                end else begin
                    r_pos <= r_pos + PW'(1);
                end
            end
            // second stage: add the finished symbol while below the minimum length
            if (r_s2_vld && (r_count < i_min_len)) begin
                r_sum   <= r_sum + lmie_pkg::SUM_W'(r_s2_dev);
                r_count <= r_count + lmie_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s2_dev <= w_dev;
        end
    end

    assign o_sum   = r_sum;
    assign o_count = r_count;

endmodule

[hw/rtl/lmie_est.sv]
// ----------------------------------------------------------------------------
// lmie_est
// estimate datapath: scaling multiply, bit-serial divider, output register
// ----------------------------------------------------------------------------
module lmie_est (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lmie_pkg::t_est_cmd                   i_cmd,
    output lmie_pkg::t_est_sts                   o_sts,
    input  logic [lmie_pkg::SUM_W-1:0]           i_sum,
    input  logic [lmie_pkg::CNT_W-1:0]           i_count,
    input  logic [lmie_pkg::CNT_W-1:0]           i_min_len,
    input  logic [lmie_pkg::BITS_W-1:0]          i_eff_bits,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [lmie_pkg::OUT_W-1:0]    o_mi_estimate,
    output logic                                 o_incomplete
);

    logic [lmie_pkg::PROD_W-1:0]          r_plo;
    logic [lmie_pkg::PROD_W-1:0]          r_phi;
    logic [lmie_pkg::DVD_W-1:0]           r_dvd;
    logic [lmie_pkg::CNT_W-1:0]           r_rem;
    logic                                 r_out_vld;
    logic signed [lmie_pkg::OUT_W-1:0]    r_mi;
    logic                                 r_nf;

    logic [lmie_pkg::PRODX_W-1:0]         w_x;
    logic [lmie_pkg::CNT_W:0]             w_rem_sh;
    logic                                 w_ge;
    logic [lmie_pkg::CNT_W:0]             w_rem_sub;
    logic                                 w_sat;
    logic [lmie_pkg::T_SRC_W:0]           w_t_sum;
    logic [lmie_pkg::T_W-1:0]             w_t;
    logic signed [23:0]                   w_v;
    logic signed [lmie_pkg::OUT_W-1:0]    w_mi;

    assign w_x = {r_phi, lmie_pkg::HALF_W'(0)} + lmie_pkg::PRODX_W'(r_plo);

    // restoring division, one quotient bit per step shifted into the dividend
    assign w_rem_sh  = {r_rem, r_dvd[lmie_pkg::DVD_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, i_count});
    assign w_rem_sub = w_rem_sh - {1'b0, i_count};

    assign w_sat   = (r_dvd >= lmie_pkg::SAT_LIMIT);
    assign w_t_sum = {1'b0, r_dvd[lmie_pkg::T_SRC_W-1:0]} + lmie_pkg::ROUND_Q30;
    assign w_t     = w_t_sum[lmie_pkg::T_SRC_W:30];
    assign w_v     = $signed({9'b0, i_eff_bits, 12'b0}) - $signed({2'b0, w_t});

    always_comb begin
        if (i_count == '0) begin
            w_mi = '0;
        end else if (w_sat || (w_v < -24'sd32768)) begin
            w_mi = lmie_pkg::OUT_MIN;
        end else if (w_v > 24'sd32767) begin
            w_mi = lmie_pkg::OUT_MAX;
        end else begin
            w_mi = w_v[lmie_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_lo) begin
            r_plo <= lmie_pkg::PROD_W'(i_sum[lmie_pkg::HALF_W-1:0]) *
                     lmie_pkg::PROD_W'(lmie_pkg::LOG2E_Q30);
        end
        if (i_cmd.mul_hi) begin
            r_phi <= lmie_pkg::PROD_W'(i_sum[lmie_pkg::SUM_W-1:lmie_pkg::HALF_W]) *
                     lmie_pkg::PROD_W'(lmie_pkg::LOG2E_Q30);
        end
        if (i_cmd.dvd_load) begin
            r_dvd <= {w_x, 4'b0};
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[lmie_pkg::DVD_W-2:0], w_ge};
            r_rem <= w_ge ? w_rem_sub[lmie_pkg::CNT_W-1:0] : w_rem_sh[lmie_pkg::CNT_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_mi <= w_mi;
            r_nf <= (i_count < i_min_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_out_vld || i_ready;
    assign o_valid        = r_out_vld;
    assign o_mi_estimate  = r_mi;
    assign o_incomplete   = r_nf;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_vld)
        else $error("estimate loaded over a pending transfer");

    a_vld_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_ready) |=> r_out_vld)
        else $error("estimate dropped before transfer");

endmodule

[hw/rtl/lmie_ctrl.sv]
// ----------------------------------------------------------------------------
// lmie_ctrl
// sequencer for the per-frame estimate computation
// ----------------------------------------------------------------------------
module lmie_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_frame_end,
    input  lmie_pkg::t_est_sts   i_sts,
    output lmie_pkg::t_est_cmd   o_cmd,
    output logic                 o_in_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAIN,
        S_MUL_LO,
        S_MUL_HI,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_state;

    t_state                          r_state;
    lmie_pkg::t_est_cmd              r_cmd;
    logic [lmie_pkg::STEP_W-1:0]     r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= '0;
            r_step  <= '0;
        end else begin
            r_cmd <= '0;
            case (r_state)
                S_IDLE: begin
                    if (i_accept && i_frame_end) begin
                        r_state <= S_DRAIN;
                    end
                end
                // let the last symbol reach the sum
                S_DRAIN: begin
                    r_state      <= S_MUL_LO;
                    r_cmd.mul_lo <= 1'b1;
                end
                S_MUL_LO: begin
                    r_state      <= S_MUL_HI;
                    r_cmd.mul_hi <= 1'b1;
                end
                S_MUL_HI: begin
                    r_state        <= S_LOAD;
                    r_cmd.dvd_load <= 1'b1;
                end
                S_LOAD: begin
                    r_state        <= S_DIV;
                    r_cmd.div_step <= 1'b1;
                    r_step         <= '0;
                end
                S_DIV: begin
                    r_step <= r_step + lmie_pkg::STEP_W'(1);
                    if (r_step == lmie_pkg::STEP_W'(lmie_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cmd.div_step <= 1'b1;
                    end
                end
                S_DONE: begin
                    if (i_sts.out_free) begin
                        r_state        <= S_IDLE;
                        r_cmd.out_load <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cmd      = r_cmd;
    assign o_in_ready = (r_state == S_IDLE);

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_cmd))
        else $error("more than one datapath command at once");

    a_step_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.div_step |-> (r_state == S_DIV))
        else $error("divider stepped outside the division phase");

    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_frame_end) |=> (r_state == S_DRAIN) && !o_in_ready)
        else $error("frame end did not start the estimate");

endmodule

[hw/rtl/llr_mutual_information_estimator.sv]
// ----------------------------------------------------------------------------
// llr_mutual_information_estimator
// mutual information estimate from symbol log-likelihood metrics
// ----------------------------------------------------------------------------
// Metrics are taken one per clock cycle while no estimate is being computed;
// each symbol's max* deviation is added to the running sum in the cycle after
// its last metric is taken. A metric flagged as frame end holds the input off
// while the estimate is formed: a drain state lets the sum settle, the scaling
// multiply forms its low and high halves, the dividend is loaded, the bit-serial
// restoring divider runs, and the result is handed to the output register.
// If the previous estimate has not yet been transferred, the input stays held
// until it is. A waiting estimate does not block new metrics.
// ----------------------------------------------------------------------------
module llr_mutual_information_estimator #(
    parameter int MAX_SYMBOL_BITS        = 4,
    parameter int CORRECTION_TABLE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    lmie_in_if.sink             i_in,
    lmie_out_if.source          o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic REG_BITS    = 1'b0;
    localparam logic REG_MIN_LEN = 1'b1;

    logic [lmie_pkg::BITS_W-1:0]   r_bits;
    logic [lmie_pkg::CNT_W-1:0]    r_min_len;

    logic [lmie_pkg::BITS_W-1:0]   w_eff_bits;
    logic                          w_wr;
    logic                          w_accept;
    logic                          w_in_ready;
    logic [lmie_pkg::SUM_W-1:0]    w_sum;
    logic [lmie_pkg::CNT_W-1:0]    w_count;
    lmie_pkg::t_est_cmd            w_cmd;
    lmie_pkg::t_est_sts            w_sts;

    // configuration registers
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits    <= lmie_pkg::BITS_W'(1);
            r_min_len <= lmie_pkg::CNT_W'(1000);
        end else if (w_wr) begin
            case (paddr[2])
                REG_BITS:    r_bits    <= pwdata[lmie_pkg::BITS_W-1:0];
                REG_MIN_LEN: r_min_len <= pwdata[lmie_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_BITS:    prdata = {(32 - lmie_pkg::BITS_W)'(0), r_bits};
            REG_MIN_LEN: prdata = {(32 - lmie_pkg::CNT_W)'(0), r_min_len};
            default:     prdata = '0;
        endcase
    end

    // symbol size clamped to the supported range
    always_comb begin
        if (r_bits == '0) begin
            w_eff_bits = lmie_pkg::BITS_W'(1);
        end else if (r_bits > lmie_pkg::BITS_W'(MAX_SYMBOL_BITS)) begin
            w_eff_bits = lmie_pkg::BITS_W'(MAX_SYMBOL_BITS);
        end else begin
            w_eff_bits = r_bits;
        end
    end

    assign i_in.ready = w_in_ready;
    assign w_accept   = i_in.valid && w_in_ready;

    lmie_accum #(
        .MAX_SYMBOL_BITS        (MAX_SYMBOL_BITS),
        .CORRECTION_TABLE_DEPTH (CORRECTION_TABLE_DEPTH)
    ) u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_metric   (i_in.metric),
        .i_ref_bits (i_in.ref_bits),
        .i_eff_bits (w_eff_bits),
        .i_min_len  (r_min_len),
        .o_sum      (w_sum),
        .o_count    (w_count)
    );

    lmie_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_frame_end (i_in.frame_end),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_ready  (w_in_ready)
    );

    lmie_est u_est (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_sum          (w_sum),
        .i_count        (w_count),
        .i_min_len      (r_min_len),
        .i_eff_bits     (w_eff_bits),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_mi_estimate  (o_out.mi_estimate),
        .o_incomplete   (o_out.incomplete)
    );

endmodule

[sim/tb_llr_mutual_information_estimator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_llr_mutual_information_estimator
// self-checking bench for the llr mutual information estimator
// ----------------------------------------------------------------------------
// Metrics are streamed as symbol-shaped bursts with random content, random
// frame ends and random gaps on both channels. A bit-accurate predictor keeps
// its own max* deviation sum and symbol count and forms the expected estimate
// on every frame end. Register settings change between phases: out-of-range
// symbol sizes, a zero minimum length and limits reached part way through.
// ----------------------------------------------------------------------------
module tb_llr_mutual_information_estimator;

    localparam int MAX_BITS      = 4;
    localparam int CORR_DEPTH    = 16;
    localparam int MAX_WAIT      = 18;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 100;
    localparam int FRAME_ODDS    = 8;

    localparam int REG_BITS_PER_SYMBOL = 0;
    localparam int REG_MIN_LENGTH      = 1;

    typedef longint unsigned u64_t;
    localparam u64_t INV_LN2_Q30 = 64'd1549082005;

    // 256 * ln(1 + exp(-k/8)), rounded
    localparam logic [7:0] JACOBIAN_LUT [64] = '{
        8'd177, 8'd162, 8'd147, 8'd134, 8'd121, 8'd110, 8'd99, 8'd89,
        8'd80,  8'd72,  8'd64,  8'd58,  8'd52,  8'd46,  8'd41, 8'd37,
        8'd32,  8'd29,  8'd26,  8'd23,  8'd20,  8'd18,  8'd16, 8'd14,
        8'd12,  8'd11,  8'd10,  8'd9,   8'd8,   8'd7,   8'd6,  8'd5,
        8'd5,   8'd4,   8'd4,   8'd3,   8'd3,   8'd2,   8'd2,  8'd2,
        8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,  8'd1,
        8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,  8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,  8'd0
    };

    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_BURSTY} idle_mode_t;

    typedef struct {
        logic signed [lmie_pkg::METRIC_W-1:0] metric;
        logic [lmie_pkg::REF_W-1:0]           ref_bits;
        logic                                 frame_end;
        bit                                   hold_for_drain;
    } metric_item_t;

    typedef struct {
        logic signed [lmie_pkg::OUT_W-1:0] mi;
        logic                              incomplete;
    } mi_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lmie_in_if  metric_ch ();
    lmie_out_if est_ch ();

    llr_mutual_information_estimator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (metric_ch),
        .o_out   (est_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    metric_item_t metric_q [$];
    mi_result_t   estimate_q [$];

    // predictor copy of registers and accumulation state
    logic [lmie_pkg::BITS_W-1:0] cfg_bits;
    logic [lmie_pkg::CNT_W-1:0]  cfg_min_len;
    logic [lmie_pkg::SUM_W-1:0]  dev_sum;
    logic [lmie_pkg::CNT_W-1:0]  sym_count;
    int                          run_mstar;
    int                          ref_metric;
    int                          ref_idx;
    int                          sym_pos;

    idle_mode_t tx_mode;
    idle_mode_t rx_mode;
    bit         tx_busy;
    int         tx_wait;
    int         rx_wait;
    logic       in_took;
    logic       out_took;
    int         err_cnt;
    int         cycle_cnt;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int eff_bits_of(logic [lmie_pkg::BITS_W-1:0] b);
        if (b < 1) return 1;
        if (b > MAX_BITS) return MAX_BITS;
        return int'(b);
    endfunction

    function automatic int jacobian_corr(int diff);
        u64_t mag;
        u64_t slot;
        mag  = (diff < 0) ? u64_t'(-diff) : u64_t'(diff);
        slot = (mag * CORR_DEPTH) >> 11;
        if (slot >= CORR_DEPTH) return 0;
        return int'(JACOBIAN_LUT[(slot * 64) / CORR_DEPTH]);
    endfunction

    function automatic int maxstar2(int a, int b);
        return ((a > b) ? a : b) + jacobian_corr(a - b);
    endfunction

    // bits - sum / (ln2 * count) in q4.12, from the current sum and count
    function automatic mi_result_t estimate_from_sum(int eff);
        mi_result_t est;
        u64_t       scaled;
        u64_t       quo;
        u64_t       rem;
        u64_t       t;
        longint     v;
        est.incomplete = (sym_count < cfg_min_len);
        if (sym_count == 0) begin
            est.mi = '0;
        end else begin
            scaled = u64_t'(dev_sum) << 4;
            quo    = scaled / u64_t'(sym_count);
            rem    = scaled % u64_t'(sym_count);
            if (quo >= (u64_t'(1) << 20)) begin
                est.mi = lmie_pkg::OUT_MIN;
            end else begin
                t = (quo * INV_LN2_Q30 + (rem * INV_LN2_Q30) / u64_t'(sym_count)
                     + (u64_t'(1) << 29)) >> 30;
                v = longint'(eff) * 4096 - longint'(t);
                if (v < -32768) v = -32768;
                if (v > 32767) v = 32767;
                est.mi = v[lmie_pkg::OUT_W-1:0];
            end
        end
        return est;
    endfunction

    function automatic void absorb_metric(logic signed [lmie_pkg::METRIC_W-1:0] metric,
                                          logic [lmie_pkg::REF_W-1:0] rb, logic fe);
        int eff;
        int last;
        int m;
        int dev;
        eff  = eff_bits_of(cfg_bits);
        last = (1 << eff) - 1;
        m    = int'(metric);
        if (sym_pos == 0) begin
            run_mstar = m;
            ref_idx   = int'(rb) & last;
        end else begin
            run_mstar = maxstar2(run_mstar, m);
        end
        if (sym_pos == ref_idx) ref_metric = m;
        // a symbol closes at the first position at or past its last slot
        if (sym_pos >= last) begin
            dev = run_mstar - ref_metric;
            if (dev < 0) dev = 0;
            if (sym_count < cfg_min_len) begin
                dev_sum   = dev_sum + lmie_pkg::SUM_W'(dev);
                sym_count = sym_count + 1'b1;
            end
            sym_pos = 0;
        end else begin
            sym_pos = (sym_pos + 1) & 15;
        end
        if (fe) estimate_q.push_back(estimate_from_sum(eff));
    endfunction

    function automatic int draw_wait(idle_mode_t mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, MAX_WAIT);
            default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
        endcase
    endfunction

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // metric sender
    always @(negedge i_clk) begin
        metric_item_t nxt;
        if (!i_rst_n) begin
            tx_busy = 1'b0;
            tx_wait = 0;
        end else begin
            if (tx_busy && in_took) tx_busy = 1'b0;
            if (!tx_busy) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (metric_q.size() != 0 &&
                             !(metric_q[0].hold_for_drain && estimate_q.size() != 0)) begin
                    nxt = metric_q.pop_front();
                    metric_ch.metric    <= nxt.metric;
                    metric_ch.ref_bits  <= nxt.ref_bits;
                    metric_ch.frame_end <= nxt.frame_end;
                    tx_busy = 1'b1;
                    tx_wait = draw_wait(tx_mode);
                end
            end
        end
        metric_ch.valid <= tx_busy;
    end

    // estimate receiver: the stall drawn after a transfer runs while the next one is offered
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rx_wait = 0;
        end else if (out_took) begin
            rx_wait = draw_wait(rx_mode);
        end
        est_ch.ready <= (rx_wait == 0);
        if (est_ch.valid === 1'b1 && rx_wait > 0) rx_wait--;
    end

    // monitor on both channels
    always @(posedge i_clk) begin
        mi_result_t want;
        in_took  <= metric_ch.valid && metric_ch.ready;
        out_took <= est_ch.valid && est_ch.ready;
        if (i_rst_n && metric_ch.valid && metric_ch.ready) begin
            absorb_metric(metric_ch.metric, metric_ch.ref_bits, metric_ch.frame_end);
        end
        if (i_rst_n && est_ch.valid && est_ch.ready) begin
            if (estimate_q.size() == 0) begin
                $display("%0t: estimate with none expected: mi_estimate %0d incomplete %0b",
                         $time, est_ch.mi_estimate, est_ch.incomplete);
                err_cnt++;
            end else begin
                want = estimate_q.pop_front();
                if (est_ch.mi_estimate !== want.mi) begin
                    $display("%0t: mi_estimate expected %0d, got %0d",
                             $time, want.mi, est_ch.mi_estimate);
                    err_cnt++;
                end
                if (est_ch.incomplete !== want.incomplete) begin
                    $display("%0t: incomplete expected %0b, got %0b",
                             $time, want.incomplete, est_ch.incomplete);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: run did not complete in time", $time);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic apb_access(int idx, bit wr, logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= 3'(idx * 4);
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        if (wr) begin
            if (idx == REG_BITS_PER_SYMBOL) cfg_bits = wdata[lmie_pkg::BITS_W-1:0];
            else cfg_min_len = wdata[lmie_pkg::CNT_W-1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(int idx);
        logic [31:0] got;
        logic [31:0] want;
        apb_access(idx, 1'b0, '0, got);
        want = (idx == REG_BITS_PER_SYMBOL) ? 32'(cfg_bits) : 32'(cfg_min_len);
        if (got !== want) begin
            $display("%0t: register %0d expected %0h, got %0h", $time, idx, want, got);
            err_cnt++;
        end
    endtask

    task automatic write_reg(int idx, logic [31:0] value);
        logic [31:0] unused;
        apb_access(idx, 1'b1, value, unused);
        check_reg(idx);
    endtask

    task automatic queue_item(int metric, int rb, bit fe);
        metric_item_t it;
        it.metric         = metric[lmie_pkg::METRIC_W-1:0];
        it.ref_bits       = rb[lmie_pkg::REF_W-1:0];
        it.frame_end      = fe;
        it.hold_for_drain = 1'b0;
        metric_q.push_back(it);
    endtask

    // one symbol; mostly the reference metric leads, as from a working decoder
    task automatic queue_symbol(int eff);
        int n;
        int rb;
        int idx;
        int shape;
        int common;
        int m;
        int k;
        n      = 1 << eff;
        rb     = $urandom_range(0, 15);
        idx    = rb & (n - 1);
        shape  = $urandom_range(0, 9);
        common = rand_between(-20000, 20000);
        for (k = 0; k < n; k++) begin
            case (shape)
                6, 7: m = rand_between(-32768, 32767);
                8: begin
                    case ($urandom_range(0, 3))
                        0: m = -32768;
                        1: m = 32767;
                        2: m = 0;
                        default: m = -1;
                    endcase
                end
                // close values walk the whole correction range
                9: m = common + rand_between(0, 2200);
                default: m = (k == idx) ? rand_between(256, 4096) : rand_between(-4096, 1536);
            endcase
            queue_item(m, (shape == 6) ? int'($urandom_range(0, 15)) : rb,
                       $urandom_range(1, FRAME_ODDS) == 1);
        end
    endtask

    task automatic wait_idle();
        while (metric_q.size() != 0 || tx_busy || estimate_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random_phase(int bits_val, int min_val, idle_mode_t tx_m,
                                    idle_mode_t rx_m);
        int           eff;
        int           last;
        int           fill;
        bit           held;
        metric_item_t tail;
        write_reg(REG_BITS_PER_SYMBOL, bits_val);
        write_reg(REG_MIN_LENGTH, min_val);
        tx_mode = tx_m;
        rx_mode = rx_m;
        eff  = eff_bits_of(cfg_bits);
        last = (1 << eff) - 1;
        // finish any partial symbol so the bursts line up with symbol slots
        if (sym_pos == 0) fill = 0;
        else if (sym_pos >= last) fill = 1;
        else fill = last - sym_pos + 1;
        repeat (fill) begin
            queue_item(rand_between(-32768, 32767), $urandom_range(0, 15),
                       $urandom_range(0, 7) == 0);
        end
        held = 1'b0;
        while (metric_q.size() < PHASE_ITEMS) begin
            queue_symbol(eff);
            if (!held && metric_q.size() >= PHASE_ITEMS / 2) begin
                tail = metric_q.pop_back();
                tail.hold_for_drain = 1'b1;
                metric_q.push_back(tail);
                held = 1'b1;
            end
        end
        wait_idle();
    endtask

    initial begin
        int ph;
        int bits_val;
        int min_val;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        metric_ch.valid     = 1'b0;
        metric_ch.metric    = '0;
        metric_ch.ref_bits  = '0;
        metric_ch.frame_end = 1'b0;
        est_ch.ready        = 1'b0;
        cfg_bits            = 3'd1;
        cfg_min_len         = 24'd1000;
        dev_sum             = '0;
        sym_count           = '0;
        run_mstar           = 0;
        ref_metric          = 0;
        ref_idx             = 0;
        sym_pos             = 0;
        tx_mode             = IDLE_NONE;
        rx_mode             = IDLE_NONE;
        err_cnt             = 0;
        cycle_cnt           = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        check_reg(REG_BITS_PER_SYMBOL);
        check_reg(REG_MIN_LENGTH);

        // frame end before any symbol completes, upper reference bits masked off
        queue_item(-32768, 4'b1110, 1'b1);
        wait_idle();

        // symbol size raised mid-symbol; max* corrections push the ratio out of range
        write_reg(REG_BITS_PER_SYMBOL, 2);
        queue_item(32767, 0, 1'b0);
        queue_item(32767, 0, 1'b0);
        queue_item(32767, 0, 1'b1);
        // equal metrics stack the largest corrections
        queue_item(0, 4'b1111, 1'b0);
        queue_item(0, 4'b1111, 1'b0);
        queue_item(0, 4'b1111, 1'b0);
        queue_item(0, 4'b1111, 1'b1);
        // differences beyond the table and at the last non-zero entry, frame end mid-symbol
        queue_item(100, 4'b0101, 1'b0);
        queue_item(-4000, 4'b0101, 1'b1);
        queue_item(-1563, 4'b0101, 1'b0);
        queue_item(-1563, 4'b0101, 1'b0);
        wait_idle();

        write_reg(REG_BITS_PER_SYMBOL, 4);
        queue_item(32767, 4'b1010, 1'b0);
        queue_item(-32768, 4'b1010, 1'b1);
        queue_item(12345, 4'b1010, 1'b0);
        wait_idle();

        // size lowered below the current position: the next metric closes the symbol
        write_reg(REG_BITS_PER_SYMBOL, 1);
        queue_item(5, 4'b0000, 1'b1);
        queue_item(-7, 4'b0001, 1'b0);
        queue_item(300, 4'b0001, 1'b1);
        wait_idle();

        write_reg(REG_BITS_PER_SYMBOL, 0);
        queue_item(1000, 4'b0000, 1'b0);
        queue_item(-1000, 4'b0000, 1'b1);
        wait_idle();

        // oversized symbol setting with nothing to accumulate
        write_reg(REG_BITS_PER_SYMBOL, 7);
        write_reg(REG_MIN_LENGTH, 0);
        queue_item(-1, 4'b1001, 1'b0);
        queue_item(1, 4'b1001, 1'b0);
        queue_item(-200, 4'b1001, 1'b0);
        queue_item(32767, 4'b1001, 1'b1);
        wait_idle();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin bits_val = 1; min_val = 24'hFFFFFF; end
                1: begin bits_val = 4; min_val = 24'hFFFFFF; end
                2: begin bits_val = 2; min_val = 0; end
                3: begin bits_val = 3; min_val = int'(sym_count) + $urandom_range(3, 10); end
                4: begin bits_val = 7; min_val = 1; end
                5: begin bits_val = 0; min_val = 24'hFFFFFF; end
                6: begin bits_val = 5; min_val = $urandom_range(1, 24'hFFFFFF); end
                default: begin
                    bits_val = $urandom_range(0, 7);
                    min_val  = int'(sym_count) + $urandom_range(0, 4);
                end
            endcase
            run_random_phase(bits_val, min_val, idle_mode_t'(ph % 3),
                             idle_mode_t'((ph + 1) % 3));
        end

        if (err_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
